FILE: src/dfa_lex_pkg.sv
// ----------------------------------------------------------------------------
// dfa_lex_pkg
// Shared types and constants for the DFA longest-match lexer.
// ----------------------------------------------------------------------------
package dfa_lex_pkg;

  localparam int unsigned DefMaxStates     = 256;
  localparam int unsigned DefRangesPerState = 16;
  localparam int unsigned TargetBits       = 9;
  localparam int unsigned IdBits           = 16;
  localparam int unsigned LenBits          = 16;
  localparam int unsigned CharBits         = 8;

  typedef enum logic [1:0] {
    MODE_ROW   = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_CHAR  = 2'd2,
    MODE_EOT   = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_STATE_COUNT = 1'b0,
    CFG_FORCE_LAZY  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    mode_t                  kind;
    logic [7:0]             sidx;
    logic [3:0]             slot;
    logic [CharBits-1:0]    lo;
    logic [CharBits-1:0]    hi;
    logic [TargetBits-1:0]  target;
    logic [IdBits-1:0]      accept;
    logic                   lazy;
    logic [4:0]             nranges;
    logic [CharBits-1:0]    ch;
  } item_t;

  typedef struct packed {
    logic [IdBits-1:0]      accept;
    logic                   lazy;
    logic [TargetBits-1:0]  dflt;
    logic [4:0]             nranges;
  } row_t;

  typedef struct packed {
    logic [CharBits-1:0]    lo;
    logic [CharBits-1:0]    hi;
    logic [TargetBits-1:0]  target;
  } range_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROW,
    BK_RANGE,
    BK_EMIT
  } bk_state_t;

endpackage

FILE: src/dfa_lex_front.sv
// ----------------------------------------------------------------------------
// dfa_lex_front
// Accepts input words, drops out-of-range loads, queues the rest (2 deep).
// ----------------------------------------------------------------------------
module dfa_lex_front import dfa_lex_pkg::*; #(
  parameter int unsigned MAX_STATES       = DefMaxStates,
  parameter int unsigned RANGES_PER_STATE = DefRangesPerState
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  item_t  in_word,
  output logic   q_valid,
  output item_t  q_word,
  input  logic   q_pop
);

  item_t       fifo [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        keep;
  logic        push;
  logic        is_load;

  assign is_load = (in_word.kind == MODE_ROW) || (in_word.kind == MODE_RANGE);
  assign keep = !(is_load && ((32'(in_word.sidx) >= MAX_STATES) ||
                 ((in_word.kind == MODE_RANGE) && (32'(in_word.slot) >= RANGES_PER_STATE))));
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != 2'd0);
  assign q_word   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

FILE: src/dfa_lex_back.sv
// ----------------------------------------------------------------------------
// dfa_lex_back
// Table memories and the DFA walker: row read, serial range search, emit.
// ----------------------------------------------------------------------------
module dfa_lex_back import dfa_lex_pkg::*; #(
  parameter int unsigned MAX_STATES       = DefMaxStates,
  parameter int unsigned RANGES_PER_STATE = DefRangesPerState
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  item_t                  q_word,
  output logic                   q_pop,
  input  logic [TargetBits-1:0]  state_count,
  input  logic                   force_nongreedy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IdBits-1:0]      out_id,
  output logic [LenBits-1:0]     out_len
);

  localparam int unsigned SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned RD  = MAX_STATES * RANGES_PER_STATE;
  localparam int unsigned RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int unsigned IW  = $clog2(RANGES_PER_STATE + 1);

  row_t    row_mem [MAX_STATES];
  range_t  rng_mem [RD];
  row_t    row_rd;
  range_t  rng_rd;

  bk_state_t              state, state_next;
  logic [SW-1:0]          cur, cur_next;
  logic [LenBits-1:0]     consumed, consumed_next;
  logic [IdBits-1:0]      best_id, best_id_next;
  logic [LenBits-1:0]     best_len, best_len_next;
  item_t                  item, item_next;
  logic [TargetBits-1:0]  dflt, dflt_next;
  logic [IW-1:0]          n, n_next;
  logic [IW-1:0]          idx, idx_next;
  logic                   out_valid_next;
  logic [IdBits-1:0]      out_id_next;
  logic [LenBits-1:0]     out_len_next;

  logic                   row_we;
  logic                   rng_we;
  logic [SW-1:0]          row_wa;
  logic [RAW-1:0]         rng_wa;
  logic [RAW-1:0]         rng_ra;
  logic [IW-1:0]          rd_slot;
  logic                   slot_free;
  logic [IW-1:0]          n_row;
  logic [TargetBits-1:0]  nx;
  logic                   decide;
  logic                   hit;
  logic                   acc;

  assign row_wa  = SW'(q_word.sidx);
  assign rng_wa  = RAW'(32'(q_word.sidx) * RANGES_PER_STATE + 32'(q_word.slot));
  assign rd_slot = (state == BK_RANGE) ? idx + IW'(1) : '0;
  assign rng_ra  = RAW'(32'(cur) * RANGES_PER_STATE + 32'(rd_slot));
  assign slot_free = !out_valid || !out_stall;
  assign n_row = (32'(row_rd.nranges) > RANGES_PER_STATE) ? IW'(RANGES_PER_STATE)
                                                          : IW'(row_rd.nranges);
  assign hit = (rng_rd.lo <= item.ch) && (item.ch <= rng_rd.hi);
  assign acc = (row_rd.accept != '0);

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= '{q_word.accept, q_word.lazy, q_word.target,
                                     q_word.nranges};
    row_rd <= row_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rng_we) rng_mem[rng_wa] <= '{q_word.lo, q_word.hi, q_word.target};
    rng_rd <= rng_mem[rng_ra];
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    consumed_next  = consumed;
    best_id_next   = best_id;
    best_len_next  = best_len;
    item_next      = item;
    dflt_next      = dflt;
    n_next         = n;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    out_id_next    = out_id;
    out_len_next   = out_len;
    q_pop          = 1'b0;
    row_we         = 1'b0;
    rng_we         = 1'b0;
    decide         = 1'b0;
    nx             = dflt;

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_word.kind)
            MODE_ROW:   row_we = 1'b1;
            MODE_RANGE: rng_we = 1'b1;
            default: begin
              item_next  = q_word;
              state_next = BK_ROW;
            end
          endcase
        end
      end
      BK_ROW: begin
        if (acc) begin
          best_id_next  = row_rd.accept;
          best_len_next = consumed;
        end
        dflt_next = row_rd.dflt;
        n_next    = n_row;
        idx_next  = '0;
        if ((item.kind == MODE_EOT) || (acc && (force_nongreedy || row_rd.lazy))) begin
          state_next = BK_EMIT;
        end else if (n_row == '0) begin
          decide = 1'b1;
          nx     = row_rd.dflt;
        end else begin
          state_next = BK_RANGE;
        end
      end
      BK_RANGE: begin
        if (hit) begin
          decide = 1'b1;
          nx     = rng_rd.target;
        end else if (idx + IW'(1) == n) begin
          decide = 1'b1;
          nx     = dflt;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_id_next    = best_id;
          out_len_next   = best_len;
          cur_next       = '0;
          consumed_next  = '0;
          best_id_next   = '0;
          best_len_next  = '0;
          state_next     = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase

    if (decide) begin
      if ((nx == state_count) || (32'(nx) >= MAX_STATES)) begin
        state_next = BK_EMIT;
      end else begin
        cur_next   = SW'(nx);
        if (consumed != '1) consumed_next = consumed + LenBits'(1);
        state_next = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cur       <= '0;
      consumed  <= '0;
      best_id   <= '0;
      best_len  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      consumed  <= consumed_next;
      best_id   <= best_id_next;
      best_len  <= best_len_next;
      out_valid <= out_valid_next;
    end
    item    <= item_next;
    dflt    <= dflt_next;
    n       <= n_next;
    idx     <= idx_next;
    out_id  <= out_id_next;
    out_len <= out_len_next;
  end

endmodule

FILE: src/dfa_longest_match_lexer_unit.sv
// ----------------------------------------------------------------------------
// dfa_longest_match_lexer_unit
// Table loads are written into the table memories by the walker while idle; the input queue registers each word.
// A character reads its state's row and, if the row has range entries, is then matched by a
// serial search through the range memory read port until a hit or the last entry searched.
// End of text or a match end passes through the emit state, which waits out any result stall; one word in the walker.
// Synchronous reset clears walker state and config; table memories are not cleared.
// ----------------------------------------------------------------------------
module dfa_longest_match_lexer_unit import dfa_lex_pkg::*; #(
  parameter int unsigned MAX_STATES       = DefMaxStates,
  parameter int unsigned RANGES_PER_STATE = DefRangesPerState
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             mode,
  input  logic [7:0]             state_index,
  input  logic [3:0]             range_slot,
  input  logic [CharBits-1:0]    range_low,
  input  logic [CharBits-1:0]    range_high,
  input  logic [TargetBits-1:0]  target_state,
  input  logic [IdBits-1:0]      accept_id,
  input  logic                   lazy_mark,
  input  logic [4:0]             range_count,
  input  logic [CharBits-1:0]    character,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [IdBits-1:0]      token_id,
  output logic [LenBits-1:0]     match_length,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [TargetBits-1:0]  cfg_data
);

  item_t                  in_word;
  item_t                  q_word;
  logic                   q_valid;
  logic                   q_pop;
  logic [TargetBits-1:0]  state_count;
  logic                   force_nongreedy;

  assign cfg_ready = 1'b1;
  assign in_word = '{mode_t'(mode), state_index, range_slot, range_low, range_high,
                     target_state, accept_id, lazy_mark, range_count, character};

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count     <= TargetBits'(1);
      force_nongreedy <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STATE_COUNT: state_count     <= cfg_data;
        CFG_FORCE_LAZY:  force_nongreedy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dfa_lex_front #(
    .MAX_STATES       (MAX_STATES),
    .RANGES_PER_STATE (RANGES_PER_STATE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_stall (item_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  dfa_lex_back #(
    .MAX_STATES       (MAX_STATES),
    .RANGES_PER_STATE (RANGES_PER_STATE)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_pop           (q_pop),
    .state_count     (state_count),
    .force_nongreedy (force_nongreedy),
    .out_valid       (result_valid),
    .out_stall       (result_stall),
    .out_id          (token_id),
    .out_len         (match_length)
  );

endmodule
